[sv/ops_pkg.sv]
`timescale 1ns / 1ps

package ops_pkg;

  // Bitmap word size and default sieve capacity
  localparam int WORD_BITS    = 32;
  localparam int CAPACITY_DEF = 65536;
  localparam int WHEEL_LEN    = 15;

  // Wheel over odd numbers: odd multiples of 3 and 5 cleared, period 15 words
  localparam logic [WORD_BITS-1:0] WHEEL [WHEEL_LEN] = '{
    32'd1706347369, 32'd2574070490, 32'd2791001270, 32'd1771492141, 32'd3664098507,
    32'd3063508274, 32'd765877068,  32'd3412694739, 32'd853173684,  32'd1287035245,
    32'd3542984283, 32'd3033229718, 32'd1832049253, 32'd1531754137, 32'd2530422182
  };

  // Word 0 after fixing the small entries: 1 is not prime, 3 and 5 are
  localparam logic [WORD_BITS-1:0] WHEEL0_FIX = (WHEEL[0] & ~32'd1) | 32'd6;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_SET_LIMIT,
    OP_FILL,
    OP_P_INIT,
    OP_SQUARE,
    OP_RD_P,
    OP_Q_INIT,
    OP_RD_Q,
    OP_WR_Q,
    OP_P_INC,
    OP_RD_N,
    OP_RESULT,
    OP_TRIVIAL
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_TRIVIAL,
    C_SIEVED,
    C_FILL_MORE,
    C_SQ_GE_LIMIT,
    C_PBIT_CLEAR,
    C_Q_GE_LIMIT
  } cond_t;

  // Program steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_SETUP,
    S_FILL,
    S_PINIT,
    S_SQUARE,
    S_PTEST,
    S_QINIT,
    S_CLR_RD,
    S_CLR_WR,
    S_NEXTP,
    S_LOOKUP,
    S_ANSWER,
    S_TRIVIAL
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  hold_out;
  } ctrl_t;

  typedef struct packed {
    logic no_item;
    logic trivial;
    logic sieved;
    logic fill_more;
    logic sq_ge_limit;
    logic pbit_clear;
    logic q_ge_limit;
    logic out_busy;
  } status_t;

  // Control store
  function automatic ctrl_t ucode_rom(input step_t s);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_NEVER, target: S_IDLE, hold_out: 1'b0};
    unique case (s)
      S_IDLE:    w = '{op: OP_LATCH,     cond: C_NO_ITEM,     target: S_IDLE,    hold_out: 1'b0};
      S_DECODE:  w = '{op: OP_NOP,       cond: C_TRIVIAL,     target: S_TRIVIAL, hold_out: 1'b0};
      S_CHECK:   w = '{op: OP_NOP,       cond: C_SIEVED,      target: S_ANSWER,  hold_out: 1'b0};
      S_SETUP:   w = '{op: OP_SET_LIMIT, cond: C_NEVER,       target: S_IDLE,    hold_out: 1'b0};
      S_FILL:    w = '{op: OP_FILL,      cond: C_FILL_MORE,   target: S_FILL,    hold_out: 1'b0};
      S_PINIT:   w = '{op: OP_P_INIT,    cond: C_NEVER,       target: S_IDLE,    hold_out: 1'b0};
      S_SQUARE:  w = '{op: OP_SQUARE,    cond: C_NEVER,       target: S_IDLE,    hold_out: 1'b0};
      S_PTEST:   w = '{op: OP_RD_P,      cond: C_SQ_GE_LIMIT, target: S_LOOKUP,  hold_out: 1'b0};
      S_QINIT:   w = '{op: OP_Q_INIT,    cond: C_PBIT_CLEAR,  target: S_NEXTP,   hold_out: 1'b0};
      S_CLR_RD:  w = '{op: OP_RD_Q,      cond: C_Q_GE_LIMIT,  target: S_NEXTP,   hold_out: 1'b0};
      S_CLR_WR:  w = '{op: OP_WR_Q,      cond: C_ALWAYS,      target: S_CLR_RD,  hold_out: 1'b0};
      S_NEXTP:   w = '{op: OP_P_INC,     cond: C_ALWAYS,      target: S_SQUARE,  hold_out: 1'b0};
      S_LOOKUP:  w = '{op: OP_RD_N,      cond: C_NEVER,       target: S_IDLE,    hold_out: 1'b0};
      S_ANSWER:  w = '{op: OP_RESULT,    cond: C_ALWAYS,      target: S_IDLE,    hold_out: 1'b1};
      S_TRIVIAL: w = '{op: OP_TRIVIAL,   cond: C_ALWAYS,      target: S_IDLE,    hold_out: 1'b1};
      default:   w = '{op: OP_NOP,       cond: C_ALWAYS,      target: S_IDLE,    hold_out: 1'b0};
    endcase
    return w;
  endfunction

endpackage

[sv/ops_useq.sv]
`timescale 1ns / 1ps

module ops_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  ops_pkg::status_t status,
  output ops_pkg::ctrl_t   ctrl,
  output ops_pkg::step_t   step
);

  ops_pkg::step_t step_r;
  ops_pkg::step_t step_nxt;
  logic           cond_hit;

  // Control word for the current step
  assign ctrl = ops_pkg::ucode_rom(step_r);
  assign step = step_r;

  // Jump condition select
  always_comb begin
    unique case (ctrl.cond)
      ops_pkg::C_NEVER:       cond_hit = 1'b0;
      ops_pkg::C_ALWAYS:      cond_hit = 1'b1;
      ops_pkg::C_NO_ITEM:     cond_hit = status.no_item;
      ops_pkg::C_TRIVIAL:     cond_hit = status.trivial;
      ops_pkg::C_SIEVED:      cond_hit = status.sieved;
      ops_pkg::C_FILL_MORE:   cond_hit = status.fill_more;
      ops_pkg::C_SQ_GE_LIMIT: cond_hit = status.sq_ge_limit;
      ops_pkg::C_PBIT_CLEAR:  cond_hit = status.pbit_clear;
      ops_pkg::C_Q_GE_LIMIT:  cond_hit = status.q_ge_limit;
      default:                cond_hit = 1'b0;
    endcase
  end

  // Step counter: hold on a blocked result, jump, or advance
  always_comb begin
    priority if (ctrl.hold_out && status.out_busy) begin
      step_nxt = step_r;
    end else if (cond_hit) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = ops_pkg::step_t'(4'(step_r) + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ops_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[sv/ops_datapath.sv]
`timescale 1ns / 1ps

module ops_datapath #(
  parameter int CAPACITY = ops_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ops_pkg::ctrl_t   ctrl,
  input  logic             in_valid,
  input  logic [31:0]      in_query_value,
  input  logic             out_stall,
  output ops_pkg::status_t status,
  output logic             out_valid,
  output logic             out_prime_flag,
  output logic             out_out_of_range
);

  localparam int WB    = ops_pkg::WORD_BITS;
  localparam int WORDS = ((CAPACITY / 2) + WB - 1) / WB;
  localparam int AW    = $clog2(WORDS);
  localparam int BSH   = $clog2(WB);
  localparam int LIMW  = $clog2(CAPACITY + 1);
  localparam int PW    = LIMW;
  localparam int QW    = LIMW + 1;
  localparam int SQW   = 2 * PW;
  localparam int WHW   = $clog2(ops_pkg::WHEEL_LEN);

  // Bitmap: one bit per odd number, bit k stands for 2k+1
  logic [WB-1:0]   mem [WORDS];
  logic [WB-1:0]   rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WB-1:0]   wr_data;

  logic [31:0]     n_r,     n_nxt;
  logic [LIMW-1:0] limit_r, limit_nxt;
  logic [AW-1:0]   word_r,  word_nxt;
  logic [WHW-1:0]  wheel_r, wheel_nxt;
  logic [PW-1:0]   p_r,     p_nxt;
  logic [SQW-1:0]  sq_r,    sq_nxt;
  logic [QW-1:0]   q_r,     q_nxt;
  logic [QW-1:0]   stride_r, stride_nxt;
  logic            out_valid_r,  out_valid_nxt;
  logic            out_prime_r,  out_prime_nxt;
  logic            out_oor_r,    out_oor_nxt;
  logic            out_busy;
  logic            out_fire;

  assign out_busy = out_valid_r && out_stall;
  assign out_fire = ((ctrl.op == ops_pkg::OP_RESULT) || (ctrl.op == ops_pkg::OP_TRIVIAL))
                    && !out_busy;

  // Status flags for the sequencer
  always_comb begin
    status.no_item     = !in_valid;
    status.trivial     = !n_r[0] || (n_r >= 32'(CAPACITY));
    status.sieved      = n_r < 32'(limit_r);
    status.fill_more   = word_r != AW'(WORDS - 1);
    status.sq_ge_limit = sq_r >= SQW'(limit_r);
    status.pbit_clear  = !rd_data_r[p_r[BSH:1]];
    status.q_ge_limit  = q_r >= QW'(limit_r);
    status.out_busy    = out_busy;
  end

  // Bitmap read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (ctrl.op)
      ops_pkg::OP_LATCH: begin
        rd_en   = 1'b1;
        rd_addr = in_query_value[AW+BSH:BSH+1];
      end
      ops_pkg::OP_RD_P: begin
        rd_en   = 1'b1;
        rd_addr = p_r[AW+BSH:BSH+1];
      end
      ops_pkg::OP_RD_Q: begin
        rd_en   = 1'b1;
        rd_addr = q_r[AW+BSH:BSH+1];
      end
      ops_pkg::OP_RD_N: begin
        rd_en   = 1'b1;
        rd_addr = n_r[AW+BSH:BSH+1];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  // Bitmap write port: wheel fill or clearing one multiple
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (ctrl.op)
      ops_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_addr = word_r;
        wr_data = (word_r == '0) ? ops_pkg::WHEEL0_FIX : ops_pkg::WHEEL[wheel_r];
      end
      ops_pkg::OP_WR_Q: begin
        wr_en   = 1'b1;
        wr_addr = q_r[AW+BSH:BSH+1];
        wr_data = rd_data_r & ~(WB'(1) << q_r[BSH:1]);
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Register updates per operation
  always_comb begin
    n_nxt         = n_r;
    limit_nxt     = limit_r;
    word_nxt      = word_r;
    wheel_nxt     = wheel_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    q_nxt         = q_r;
    stride_nxt    = stride_r;
    out_prime_nxt = out_prime_r;
    out_oor_nxt   = out_oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (ctrl.op)
      ops_pkg::OP_LATCH: begin
        if (in_valid) begin
          n_nxt = in_query_value;
        end
      end
      ops_pkg::OP_SET_LIMIT: begin
        limit_nxt = LIMW'(n_r) + LIMW'(1);
        word_nxt  = '0;
        wheel_nxt = '0;
      end
      ops_pkg::OP_FILL: begin
        word_nxt  = word_r + AW'(1);
        wheel_nxt = (wheel_r == WHW'(ops_pkg::WHEEL_LEN - 1)) ? '0 : wheel_r + WHW'(1);
      end
      ops_pkg::OP_P_INIT: begin
        p_nxt = PW'(7);
      end
      ops_pkg::OP_SQUARE: begin
        sq_nxt = SQW'(p_r) * SQW'(p_r);
      end
      ops_pkg::OP_Q_INIT: begin
        q_nxt      = QW'(sq_r);
        stride_nxt = {QW'(p_r)} << 1;
      end
      ops_pkg::OP_WR_Q: begin
        q_nxt = q_r + stride_r;
      end
      ops_pkg::OP_P_INC: begin
        p_nxt = p_r + PW'(2);
      end
      ops_pkg::OP_RESULT: begin
        if (out_fire) begin
          out_prime_nxt = rd_data_r[n_r[BSH:1]];
          out_oor_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end
      ops_pkg::OP_TRIVIAL: begin
        if (out_fire) begin
          out_prime_nxt = n_r == 32'd2;
          out_oor_nxt   = n_r[0];
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        n_nxt = n_r;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    word_r      <= word_nxt;
    wheel_r     <= wheel_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    q_r         <= q_nxt;
    stride_r    <= stride_nxt;
    out_prime_r <= out_prime_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prime_flag   = out_prime_r;
  assign out_out_of_range = out_oor_r;

endmodule

[sv/odd_only_prime_sieve.sv]
`timescale 1ns / 1ps
// Primality test backed by an odd-only sieve bitmap of CAPACITY/64 words.
// Input channel: in_valid / in_stall carry in_query_value (32-bit unsigned).
// Result channel: out_valid / out_stall carry out_prime_flag and
// out_out_of_range, exactly one result per input transaction, in order.
// A transaction is taken only while the control program sits at its idle step.
// Even queries and odd queries at or above CAPACITY: result registered by
// the trivial answer step after decode, next transaction taken at the idle step.
// Odd queries below the sieved limit: answered from the bitmap word read at the
// latch step after the decode and check steps, next query taken at the idle step.
// Odd queries at or above the sieved limit first rebuild the bitmap: one
// wheel word written per cycle, then for each odd p with p*p below the
// limit the square, p-test, q-init and next-p steps, one more read step
// when p is still marked prime, and a read and a write step per cleared
// multiple, all through the bitmap read and write ports.
// Reset clears the sieved limit and the result valid flag; the bitmap itself
// is not cleared, since the first odd query below CAPACITY always rebuilds it.
// A stalled result holds its register; a finished transaction waits at the
// answer step, and the next input is accepted once the result is loaded.

module odd_only_prime_sieve #(
  parameter int CAPACITY = ops_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_query_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_prime_flag,
  output logic        out_out_of_range
);

  ops_pkg::ctrl_t   ctrl;
  ops_pkg::status_t status;
  ops_pkg::step_t   step;

  // Input is open only at the latch step
  assign in_stall = ctrl.op != ops_pkg::OP_LATCH;

  ops_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .step   (step)
  );

  ops_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_valid         (in_valid),
    .in_query_value   (in_query_value),
    .out_stall        (out_stall),
    .status           (status),
    .out_valid        (out_valid),
    .out_prime_flag   (out_prime_flag),
    .out_out_of_range (out_out_of_range)
  );

`ifndef ASSERT_OFF
  // An accepted transaction moves the program to decode
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (step == ops_pkg::S_DECODE))
    else $error("accepted transaction did not enter decode");

  // A new result only comes from one of the two answer steps
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step == ops_pkg::S_ANSWER || step == ops_pkg::S_TRIVIAL))
    else $error("result appeared outside an answer step");

  // Out-of-range answers never claim a prime
  a_oor_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_prime_flag && out_out_of_range))
    else $error("out-of-range result flagged prime");
`endif

endmodule
